### rtl/tkd_pkg.sv
// ----------------------------------------------------------------------------
// tkd_pkg
// Key codes, parser phases and the per-byte step record that the terminal
// escape key decoder shares between its files.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 5;

  localparam logic [KindW-1:0] K_CHAR  = 5'd0;
  localparam logic [KindW-1:0] K_NONE  = 5'd1;
  localparam logic [KindW-1:0] K_ESC   = 5'd2;
  localparam logic [KindW-1:0] K_BS    = 5'd3;
  localparam logic [KindW-1:0] K_UP    = 5'd4;
  localparam logic [KindW-1:0] K_DOWN  = 5'd5;
  localparam logic [KindW-1:0] K_RIGHT = 5'd6;
  localparam logic [KindW-1:0] K_LEFT  = 5'd7;
  localparam logic [KindW-1:0] K_HOME  = 5'd8;
  localparam logic [KindW-1:0] K_END   = 5'd9;
  localparam logic [KindW-1:0] K_DEL   = 5'd10;
  localparam logic [KindW-1:0] K_PGUP  = 5'd11;
  localparam logic [KindW-1:0] K_PGDN  = 5'd12;
  localparam logic [KindW-1:0] K_F1    = 5'd13;
  localparam logic [KindW-1:0] K_F5    = 5'd17;

  localparam logic [ByteW-1:0] CH_ESC   = 8'h1B;
  localparam logic [ByteW-1:0] CH_BS    = 8'h08;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7E;
  localparam logic [ByteW-1:0] CH_SS3   = 8'h4F;  // 'O'
  localparam logic [ByteW-1:0] CH_CSI   = 8'h5B;  // '['
  localparam logic [ByteW-1:0] CH_ONE   = 8'h31;  // '1'

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_SS3   = 3'd2,
    PH_CSI   = 3'd3,
    PH_ONE   = 3'd4,
    PH_DIGIT = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  code;
    phase_t            phase_next;
    logic [ByteW-1:0]  digit_next;
    logic [KindW-1:0]  pending_next;
  } step_t;

  // Key given after the discarded byte of ESC [ 2..8 x.
  function automatic logic [KindW-1:0] skip_key(input logic [ByteW-1:0] b);
    logic [KindW-1:0] k;
    case (b)
      8'h32:   k = K_NONE;
      8'h33:   k = K_DEL;
      8'h34:   k = K_END;
      8'h35:   k = K_PGUP;
      8'h36:   k = K_PGDN;
      8'h37:   k = K_HOME;
      8'h38:   k = K_END;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/tkd_decode.sv
// ----------------------------------------------------------------------------
// tkd_decode
// One parser step: from the current phase, held bytes and the new byte,
// work out the result (if any) and the next parser state.
// ----------------------------------------------------------------------------
module tkd_decode (
  input  tkd_pkg::phase_t                  phase,
  input  logic [tkd_pkg::ByteW-1:0]        held_digit,
  input  logic [tkd_pkg::KindW-1:0]        pending_key,
  input  logic [tkd_pkg::ByteW-1:0]        rx_byte,
  output tkd_pkg::step_t                   step
);
  import tkd_pkg::*;

  always_comb begin
    step              = '0;
    step.phase_next   = PH_IDLE;
    step.digit_next   = held_digit;
    step.pending_next = pending_key;
    case (phase)
      PH_ESC: begin
        if (rx_byte == CH_SS3) begin
          step.phase_next = PH_SS3;
        end else if (rx_byte == CH_CSI) begin
          step.phase_next = PH_CSI;
        end else begin
          step.emit = 1'b1;
          step.kind = K_ESC;
        end
      end
      PH_SS3: begin
        step.emit = 1'b1;
        if (rx_byte inside {[8'h50:8'h53]}) begin
          step.kind = K_F1 + KindW'(rx_byte[1:0]);
        end else begin
          step.kind = K_NONE;
        end
      end
      PH_CSI: begin
        case (rx_byte)
          8'h41: begin step.emit = 1'b1; step.kind = K_UP;    end
          8'h42: begin step.emit = 1'b1; step.kind = K_DOWN;  end
          8'h43: begin step.emit = 1'b1; step.kind = K_RIGHT; end
          8'h44: begin step.emit = 1'b1; step.kind = K_LEFT;  end
          8'h48: begin step.emit = 1'b1; step.kind = K_HOME;  end
          8'h46: begin step.emit = 1'b1; step.kind = K_END;   end
          CH_ONE: begin
            step.phase_next = PH_ONE;
          end
          default: begin
            if (rx_byte inside {[8'h32:8'h38]}) begin
              step.pending_next = skip_key(rx_byte);
              step.phase_next   = PH_SKIP;
            end else begin
              step.emit = 1'b1;
              step.kind = K_NONE;
            end
          end
        endcase
      end
      PH_ONE: begin
        if (rx_byte == CH_TILDE) begin
          step.emit = 1'b1;
          step.kind = K_HOME;
        end else begin
          step.digit_next = rx_byte;
          step.phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        step.emit = 1'b1;
        if (held_digit inside {[8'h31:8'h35]} && rx_byte == CH_TILDE) begin
          step.kind = K_F1 + KindW'(held_digit - CH_ONE);
        end else begin
          step.kind = K_HOME;
        end
      end
      PH_SKIP: begin
        step.emit = 1'b1;
        step.kind = pending_key;
      end
      default: begin
        // Idle, and the unused phase code as well.
        if (rx_byte == CH_ESC) begin
          step.phase_next = PH_ESC;
        end else if (rx_byte == CH_BS) begin
          step.emit = 1'b1;
          step.kind = K_BS;
        end else begin
          step.emit = 1'b1;
          step.kind = K_CHAR;
          step.code = rx_byte;
        end
      end
    endcase
  end

endmodule

### rtl/terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Turns received terminal bytes into key events, decoding ESC O and ESC [
// sequences into arrows, editing keys and F1..F5.
//
//   channel | dir | handshake          | payload
//   rx      | in  | rx_valid/rx_stall  | rx_byte
//   key     | out | key_valid/key_stall| key_kind, char_code
//
// One byte per cycle while the result is not stalled: an input register feeds
// the parser step, which writes the result register. A byte that completes a
// key crosses both registers in turn. Bytes inside a sequence give no result.
// key_stall holds the result register and, through it, the input register.
// rst clears the parser to idle and empties both registers.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [tkd_pkg::ByteW-1:0]     rx_byte,
  output logic                          key_valid,
  input  logic                          key_stall,
  output logic [tkd_pkg::KindW-1:0]     key_kind,
  output logic [tkd_pkg::ByteW-1:0]     char_code
);
  import tkd_pkg::*;

  logic             byte_valid;
  logic [ByteW-1:0] byte_hold;
  phase_t           phase;
  logic [ByteW-1:0] held_digit;
  logic [KindW-1:0] pending_key;
  step_t            step;
  logic             advance;

  // Parse the held byte whenever the result slot is empty or being taken.
  assign advance  = byte_valid && (!key_valid || !key_stall);
  assign rx_stall = byte_valid && !advance;

  tkd_decode u_decode (
    .phase       (phase),
    .held_digit  (held_digit),
    .pending_key (pending_key),
    .rx_byte     (byte_hold),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      phase       <= PH_IDLE;
      held_digit  <= '0;
      pending_key <= '0;
      key_valid   <= 1'b0;
    end else begin
      if (!rx_stall) begin
        byte_valid <= rx_valid;
      end
      if (key_valid && !key_stall) begin
        key_valid <= 1'b0;
      end
      if (advance) begin
        phase       <= step.phase_next;
        held_digit  <= step.digit_next;
        pending_key <= step.pending_next;
        if (step.emit) begin
          key_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      byte_hold <= rx_byte;
    end
    if (advance && step.emit) begin
      key_kind  <= step.kind;
      char_code <= step.code;
    end
  end

endmodule

### rtl/tkd_checker.sv
// ----------------------------------------------------------------------------
// tkd_checker
// Port-level checks on the key decoder's result stream.
// ----------------------------------------------------------------------------
module tkd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       key_valid,
  input logic                       key_stall,
  input logic [tkd_pkg::KindW-1:0]  key_kind,
  input logic [tkd_pkg::ByteW-1:0]  char_code
);
  import tkd_pkg::*;

  // Result slot is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !key_valid)
    else $error("key result present after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_kind <= K_F5)
    else $error("key_kind out of range");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_kind != K_CHAR |-> char_code == '0)
    else $error("char_code set on a non-character key");

  // ESC and backspace never pass through as characters.
  a_char_plain: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_kind == K_CHAR |-> char_code != CH_ESC && char_code != CH_BS)
    else $error("control byte passed through as a character");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_kind) && $stable(char_code))
    else $error("stalled key result changed");

endmodule

bind terminal_escape_key_decoder tkd_checker u_tkd_checker (
  .clk       (clk),
  .rst       (rst),
  .key_valid (key_valid),
  .key_stall (key_stall),
  .key_kind  (key_kind),
  .char_code (char_code)
);

### verif/tb_terminal_escape_key_decoder.sv
// ----------------------------------------------------------------------------
// tb_terminal_escape_key_decoder
// Self-checking bench for the terminal escape key decoder. A queue of bytes
// (directed escape sequences, a back-pressure burst and random sequences)
// feeds a bursty driver. A decoder model predicts one key per completed byte
// sequence. A monitor under a changing stall pattern checks each key.
// ----------------------------------------------------------------------------
module tb_terminal_escape_key_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import tkd_pkg::*;

  // Sequence bytes not named in the package
  localparam logic [ByteW-1:0] CH_UP_A   = 8'h41;
  localparam logic [ByteW-1:0] CH_DN_B   = 8'h42;
  localparam logic [ByteW-1:0] CH_RT_C   = 8'h43;
  localparam logic [ByteW-1:0] CH_LT_D   = 8'h44;
  localparam logic [ByteW-1:0] CH_END_F  = 8'h46;
  localparam logic [ByteW-1:0] CH_HOME_H = 8'h48;
  localparam logic [ByteW-1:0] CH_F1_P   = 8'h50;
  localparam logic [ByteW-1:0] CH_F4_S   = 8'h53;
  localparam logic [ByteW-1:0] CH_TWO    = 8'h32;
  localparam logic [ByteW-1:0] CH_THREE  = 8'h33;
  localparam logic [ByteW-1:0] CH_FIVE   = 8'h35;
  localparam logic [ByteW-1:0] CH_EIGHT  = 8'h38;
  localparam logic [ByteW-1:0] CH_NINE   = 8'h39;

  localparam int HOLD_CYCLES = 80;
  localparam int CHUNK_BYTES = 115;
  localparam int NUM_CHUNKS  = 6;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] code;
  } key_event_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             rx_valid  = 1'b0;
  logic             rx_stall;
  logic [ByteW-1:0] rx_byte   = '0;
  logic             key_valid;
  logic             key_stall = 1'b0;
  logic [KindW-1:0] key_kind;
  logic [ByteW-1:0] char_code;

  terminal_escape_key_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_byte   (rx_byte),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_kind  (key_kind),
    .char_code (char_code)
  );

  always #6 clk = ~clk;

  // Decoder model state
  phase_t           dec_phase   = PH_IDLE;
  logic [ByteW-1:0] dec_digit   = '0;
  logic [KindW-1:0] dec_pending = '0;

  logic [ByteW-1:0] byte_queue[$];
  key_event_t       key_expect_q[$];

  int  bytes_pushed   = 0;
  int  bytes_open     = 0;
  int  bytes_taken    = 0;
  int  keys_seen      = 0;
  int  mismatch_count = 0;
  int  burst_left     = 0;
  int  gap_left       = 0;
  bit  gapless        = 1'b0;
  int  hold_ask       = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  int  mode_left      = 0;
  int  cycle_cnt      = 0;
  stall_mode_t stall_mode = STALL_NONE;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Advance the decoder model by one byte; queue a key if a sequence ends.
  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic             done;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] code;
    logic [KindW-1:0] skip_lut [0:6];
    skip_lut = '{K_NONE, K_DEL, K_END, K_PGUP, K_PGDN, K_HOME, K_END};
    done = 1'b1;
    kind = K_NONE;
    code = '0;
    case (dec_phase)
      PH_ESC: begin
        if (b == CH_SS3) begin
          done = 1'b0;
          dec_phase = PH_SS3;
        end else if (b == CH_CSI) begin
          done = 1'b0;
          dec_phase = PH_CSI;
        end else begin
          kind = K_ESC;
        end
      end
      PH_SS3: begin
        if (b >= CH_F1_P && b <= CH_F4_S) kind = K_F1 + KindW'(b - CH_F1_P);
        else kind = K_NONE;
      end
      PH_CSI: begin
        if (b == CH_UP_A) kind = K_UP;
        else if (b == CH_DN_B) kind = K_DOWN;
        else if (b == CH_RT_C) kind = K_RIGHT;
        else if (b == CH_LT_D) kind = K_LEFT;
        else if (b == CH_HOME_H) kind = K_HOME;
        else if (b == CH_END_F) kind = K_END;
        else if (b == CH_ONE) begin
          done = 1'b0;
          dec_phase = PH_ONE;
        end else if (b >= CH_TWO && b <= CH_EIGHT) begin
          done = 1'b0;
          dec_pending = skip_lut[b - CH_TWO];
          dec_phase = PH_SKIP;
        end else begin
          kind = K_NONE;
        end
      end
      PH_ONE: begin
        if (b == CH_TILDE) begin
          kind = K_HOME;
        end else begin
          done = 1'b0;
          dec_digit = b;
          dec_phase = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        if (dec_digit >= CH_ONE && dec_digit <= CH_FIVE && b == CH_TILDE)
          kind = K_F1 + KindW'(dec_digit - CH_ONE);
        else
          kind = K_HOME;
      end
      PH_SKIP: kind = dec_pending;
      default: begin
        if (b == CH_ESC) begin
          done = 1'b0;
          dec_phase = PH_ESC;
        end else if (b == CH_BS) begin
          kind = K_BS;
        end else begin
          kind = K_CHAR;
          code = b;
        end
      end
    endcase
    if (done) begin
      dec_phase = PH_IDLE;
      key_expect_q.push_back('{kind: kind, code: code});
    end
  endtask

  // Sender: bursts of requests with random gaps; hold a stalled request.
  always @(posedge clk) begin : rx_driver
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        decode_byte(rx_byte);
        bytes_taken++;
        bytes_open--;
      end
      if (rx_valid && rx_stall) begin
        // hold the request as it is
      end else if (gap_left > 0 && !gapless) begin
        gap_left--;
        rx_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        rx_valid <= 1'b1;
        rx_byte <= byte_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  always @(posedge clk) begin : key_receiver
    logic stall_next;
    stall_next = 1'b0;
    cycle_cnt++;
    if (rst) begin
      key_stall <= 1'b0;
    end else begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 64);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    stall_next = ($urandom_range(0, 2) != 0);
          STALL_PERIODIC: stall_next = ((cycle_cnt % 7) < 3);
          default:        stall_next = 1'b0;
        endcase
      end
      key_stall <= stall_next;
    end
  end

  // Check each taken key against the oldest prediction.
  always @(posedge clk) begin : key_monitor
    key_event_t want;
    if (!rst && key_valid && !key_stall) begin
      keys_seen++;
      if (key_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected key kind %0d code %02h", key_kind, char_code));
      end else begin
        want = key_expect_q.pop_front();
        if (key_kind !== want.kind)
          report_mismatch($sformatf("key %0d: kind %0d, want %0d", keys_seen, key_kind,
                                    want.kind));
        if (char_code !== want.code)
          report_mismatch($sformatf("key %0d: code %02h, want %02h", keys_seen, char_code,
                                    want.code));
      end
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    byte_queue.push_back(b);
    bytes_pushed++;
    bytes_open++;
  endtask

  task automatic wait_drain();
    while (bytes_open != 0 || key_expect_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed sequences with random content; some noise and cut-offs.
  task automatic push_random_seq();
    int pick;
    logic [ByteW-1:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_byte(ByteW'($urandom));
    end else if (pick < 28) begin
      push_byte(CH_BS);
    end else if (pick < 42) begin
      push_byte(CH_ESC);
      push_byte(CH_SS3);
      if ($urandom_range(0, 4) != 0) push_byte(ByteW'($urandom_range(CH_F1_P, CH_F4_S)));
      else push_byte(ByteW'($urandom));
    end else if (pick < 62) begin
      push_byte(CH_ESC);
      push_byte(CH_CSI);
      case ($urandom_range(0, 6))
        0:       push_byte(CH_UP_A);
        1:       push_byte(CH_DN_B);
        2:       push_byte(CH_RT_C);
        3:       push_byte(CH_LT_D);
        4:       push_byte(CH_HOME_H);
        5:       push_byte(CH_END_F);
        default: push_byte(ByteW'($urandom));
      endcase
    end else if (pick < 78) begin
      push_byte(CH_ESC);
      push_byte(CH_CSI);
      push_byte(CH_ONE);
      if ($urandom_range(0, 5) == 0) begin
        push_byte(CH_TILDE);
      end else begin
        if ($urandom_range(0, 3) != 0) d = ByteW'($urandom_range(CH_ONE, CH_FIVE));
        else d = ByteW'($urandom);
        push_byte(d);
        if ($urandom_range(0, 4) != 0) push_byte(CH_TILDE);
        else push_byte(ByteW'($urandom));
      end
    end else if (pick < 92) begin
      push_byte(CH_ESC);
      push_byte(CH_CSI);
      push_byte(ByteW'($urandom_range(CH_TWO, CH_EIGHT)));
      push_byte(ByteW'($urandom));
    end else begin
      // broken: ESC followed by anything
      push_byte(CH_ESC);
      push_byte(ByteW'($urandom));
    end
  endtask

  initial begin : stimulus
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes, backspace, ESC with an unknown byte
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_BS);
    push_byte(CH_ESC); push_byte(8'h78);
    // ESC O P gives F1
    push_byte(CH_ESC); push_byte(CH_SS3); push_byte(CH_F1_P);
    // unknown byte after ESC [
    push_byte(CH_ESC); push_byte(CH_CSI); push_byte(8'h7A);
    // ESC [ 1 ~ gives home at once
    push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_ONE); push_byte(CH_TILDE);
    // ESC [ 1 5 ~ gives F5
    push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_ONE); push_byte(CH_FIVE);
    push_byte(CH_TILDE);
    // ESC [ 1 9 x: bad digit and bad terminator give home
    push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_ONE); push_byte(CH_NINE);
    push_byte(8'h41);
    // ESC inside a sequence is its discarded byte
    push_byte(CH_ESC); push_byte(CH_CSI); push_byte(CH_THREE); push_byte(CH_ESC);
    wait_drain();

    // Back-pressure: receiver holds off while the sender streams characters
    gapless = 1'b1;
    hold_ask++;
    repeat (40) push_byte(ByteW'($urandom_range(8'h20, 8'h7E)));
    wait_drain();
    gapless = 1'b0;

    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      target = bytes_pushed + CHUNK_BYTES;
      while (bytes_pushed < target) push_random_seq();
      wait_drain();
    end

    repeat (8) @(posedge clk);
    $display("Covered %0d bytes and %0d keys: directed sequences, a long receiver hold-off,",
             bytes_taken, keys_seen);
    $display("and %0d random chunks with drained pauses between them.", NUM_CHUNKS);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d bytes and %0d keys outstanding", bytes_open,
             key_expect_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
